@@ src/fct_pkg.sv @@
`timescale 1ns / 1ps
// fct_pkg: shared types, widths and codes of the frame capability table
// no dependencies; used by fct_if, fct_datapath, fct_ctrl and frame_capability_table

package fct_pkg;

    localparam int TABLE_DEPTH = 64;

    localparam int OWNER_W     = 16;
    localparam int ADDR_W      = 52;
    localparam int FRAMES_W    = 40;
    localparam int PERM_W      = 8;
    localparam int FRAME_SHIFT = 12;
    localparam int END_W       = ADDR_W + 1;
    localparam int STATUS_W    = 2;

    // entry index and fill count widths
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DENIED = 2'd2;

    localparam logic REQ_GRANT = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    typedef struct packed {
        logic [OWNER_W-1:0]  owner;
        logic [ADDR_W-1:0]   base;
        logic [FRAMES_W-1:0] frames;
        logic [PERM_W-1:0]   perms;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP_OK,
        ST_RESP_FULL,
        ST_RESP_SCAN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic                load_req;
        logic                write_entry;
        logic                scan_issue;
        logic                load_rsp;
        logic [STATUS_W-1:0] rsp_status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_check;
        logic table_full;
        logic table_empty;
        logic scan_last;
        logic pipe_empty;
        logic hit;
        logic out_free;
    } dp_sts_t;

endpackage

@@ src/fct_if.sv @@
`timescale 1ns / 1ps
// fct_req_if / fct_rsp_if: valid-ready channels of the frame capability table
// depends on fct_pkg for field widths

interface fct_req_if;
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [fct_pkg::OWNER_W-1:0]  owner;
    logic [fct_pkg::ADDR_W-1:0]   address;
    logic [fct_pkg::FRAMES_W-1:0] frames;
    logic [fct_pkg::PERM_W-1:0]   perm_bits;

    modport source (output valid, req_type, owner, address, frames, perm_bits,
                    input ready);
    modport sink (input valid, req_type, owner, address, frames, perm_bits,
                  output ready);
endinterface

interface fct_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fct_pkg::STATUS_W-1:0] status;

    modport source (output valid, status, input ready);
    modport sink (input valid, status, output ready);
endinterface

@@ src/fct_ram.sv @@
`timescale 1ns / 1ps
// fct_ram: generic single-write, single-read ram with registered read data
// no dependencies

module fct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/fct_datapath.sv @@
`timescale 1ns / 1ps
// fct_datapath: request registers, entry ram, scan compare pipeline, result register
// depends on fct_pkg and fct_ram

module fct_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fct_pkg::dp_cmd_t             cmd,
    output fct_pkg::dp_sts_t             sts,
    input  logic                         req_type,
    input  logic [fct_pkg::OWNER_W-1:0]  owner,
    input  logic [fct_pkg::ADDR_W-1:0]   address,
    input  logic [fct_pkg::FRAMES_W-1:0] frames,
    input  logic [fct_pkg::PERM_W-1:0]   perm_bits,
    output logic                         rsp_valid,
    output logic [fct_pkg::STATUS_W-1:0] rsp_status,
    input  logic                         rsp_ready
);

    // request payload
    logic                         is_check_reg;
    logic [fct_pkg::OWNER_W-1:0]  owner_reg;
    logic [fct_pkg::ADDR_W-1:0]   address_reg;
    logic [fct_pkg::FRAMES_W-1:0] frames_reg;
    logic [fct_pkg::PERM_W-1:0]   perm_reg;

    // table control
    logic [fct_pkg::CNT_W-1:0]    used_reg;
    logic [fct_pkg::IDX_W-1:0]    scan_idx_reg;

    // compare pipeline
    logic                         rd_valid_reg;
    logic                         cmp_valid_reg;
    logic                         pre_match_reg;
    logic [fct_pkg::END_W-1:0]    hi_reg;
    logic                         hit_reg;

    // result register
    logic                         out_valid_reg;
    logic [fct_pkg::STATUS_W-1:0] out_status_reg;

    fct_pkg::entry_t              wr_entry;
    fct_pkg::entry_t              rd_entry;
    logic [fct_pkg::ENTRY_W-1:0]  rd_data;
    logic [fct_pkg::END_W-1:0]    hi_next;
    logic                         pre_match_next;
    logic                         hit_now;

    assign wr_entry.owner  = owner_reg;
    assign wr_entry.base   = address_reg;
    assign wr_entry.frames = frames_reg;
    assign wr_entry.perms  = perm_reg;

    fct_ram #(
        .WIDTH (fct_pkg::ENTRY_W),
        .DEPTH (fct_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.write_entry),
        .wr_addr (used_reg[fct_pkg::IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (cmd.scan_issue),
        .rd_addr (scan_idx_reg),
        .rd_data (rd_data)
    );

    assign rd_entry = fct_pkg::entry_t'(rd_data);

    // stage one: owner, permission and lower bound, plus end of range
    always_comb
    begin
        hi_next = {1'b0, rd_entry.base}
                + {{(fct_pkg::END_W - fct_pkg::FRAMES_W - fct_pkg::FRAME_SHIFT){1'b0}},
                   rd_entry.frames, {fct_pkg::FRAME_SHIFT{1'b0}}};
        pre_match_next = (rd_entry.owner == owner_reg)
                      && ((rd_entry.perms & perm_reg) == perm_reg)
                      && (address_reg >= rd_entry.base);
    end

    // stage two: upper bound
    assign hit_now = cmp_valid_reg && pre_match_reg && ({1'b0, address_reg} < hi_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            is_check_reg <= req_type;
            owner_reg    <= owner;
            address_reg  <= address;
            frames_reg   <= frames;
            perm_reg     <= perm_bits;
        end
        if (rd_valid_reg)
        begin
            pre_match_reg <= pre_match_next;
            hi_reg        <= hi_next;
        end
        if (cmd.load_rsp)
        begin
            out_status_reg <= cmd.rsp_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            scan_idx_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write_entry)
            begin
                used_reg <= used_reg + fct_pkg::CNT_W'(1);
            end

            if (cmd.load_req)
            begin
                scan_idx_reg <= '0;
            end
            else if (cmd.scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + fct_pkg::IDX_W'(1);
            end

            rd_valid_reg  <= cmd.scan_issue;
            cmp_valid_reg <= rd_valid_reg;

            if (cmd.load_req)
            begin
                hit_reg <= 1'b0;
            end
            else if (hit_now)
            begin
                hit_reg <= 1'b1;
            end

            if (cmd.load_rsp)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.is_check    = (is_check_reg == fct_pkg::REQ_CHECK);
    assign sts.table_full  = (used_reg == fct_pkg::CNT_W'(fct_pkg::TABLE_DEPTH));
    assign sts.table_empty = (used_reg == '0);
    assign sts.scan_last   = ((fct_pkg::CNT_W'(scan_idx_reg) + fct_pkg::CNT_W'(1)) == used_reg);
    assign sts.pipe_empty  = !rd_valid_reg && !cmp_valid_reg;
    assign sts.hit         = hit_reg;
    assign sts.out_free    = !out_valid_reg || rsp_ready;

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = out_status_reg;

endmodule

@@ src/fct_ctrl.sv @@
`timescale 1ns / 1ps
// fct_ctrl: request sequencer of the frame capability table
// depends on fct_pkg

module fct_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  fct_pkg::dp_sts_t sts,
    output fct_pkg::dp_cmd_t cmd
);

    fct_pkg::state_t state_reg;
    fct_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fct_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fct_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = fct_pkg::ST_DISPATCH;
                end
            end
            fct_pkg::ST_DISPATCH:
            begin
                if (sts.is_check)
                begin
                    state_next = sts.table_empty ? fct_pkg::ST_RESP_SCAN : fct_pkg::ST_SCAN;
                end
                else
                begin
                    state_next = sts.table_full ? fct_pkg::ST_RESP_FULL : fct_pkg::ST_RESP_OK;
                end
            end
            fct_pkg::ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = fct_pkg::ST_DRAIN;
                end
            end
            fct_pkg::ST_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    state_next = fct_pkg::ST_RESP_SCAN;
                end
            end
            fct_pkg::ST_RESP_OK, fct_pkg::ST_RESP_FULL, fct_pkg::ST_RESP_SCAN:
            begin
                if (sts.out_free)
                begin
                    state_next = fct_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fct_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready       = 1'b0;
        cmd.load_req    = 1'b0;
        cmd.write_entry = 1'b0;
        cmd.scan_issue  = 1'b0;
        cmd.load_rsp    = 1'b0;
        cmd.rsp_status  = fct_pkg::STATUS_OK;
        unique case (state_reg)
            fct_pkg::ST_IDLE:
            begin
                req_ready    = 1'b1;
                cmd.load_req = req_valid;
            end
            fct_pkg::ST_DISPATCH:
            begin
                cmd.write_entry = !sts.is_check && !sts.table_full;
            end
            fct_pkg::ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            fct_pkg::ST_DRAIN:
            begin
            end
            fct_pkg::ST_RESP_OK:
            begin
                cmd.load_rsp   = sts.out_free;
                cmd.rsp_status = fct_pkg::STATUS_OK;
            end
            fct_pkg::ST_RESP_FULL:
            begin
                cmd.load_rsp   = sts.out_free;
                cmd.rsp_status = fct_pkg::STATUS_FULL;
            end
            fct_pkg::ST_RESP_SCAN:
            begin
                cmd.load_rsp   = sts.out_free;
                cmd.rsp_status = sts.hit ? fct_pkg::STATUS_OK : fct_pkg::STATUS_DENIED;
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ src/frame_capability_table.sv @@
`timescale 1ns / 1ps
// frame_capability_table: top level joining the sequencer and the datapath
// depends on fct_pkg, fct_if, fct_ram, fct_datapath and fct_ctrl
//
// req channel (sink): one transaction per request. req_type 0 grants a new
//   capability (owner, base address, frame count, permission bits) and
//   appends it to the table; req_type 1 checks owner, address and required
//   permission bits against every stored entry.
// rsp channel (source): exactly one transaction per request, in order.
//   status 0 ok / allowed, 1 table full (grant refused), 2 access denied.
// sequence: a grant, or a check on an empty table, passes from the request
//   registers through dispatch to a response state. any other check walks the
//   stored entries one per cycle through the single ram read port, then
//   drains a two-stage compare pipeline before its response state.
// flow: one request in flight; req ready is high only while idle, the
//   cycle after the result is queued.
// reset: the fill count is cleared and the table is empty; the ram is not
//   cleared, entries at or above the fill count are never read.
// stalls: the result sits in an output register and the next request is
//   taken while it waits; a later result holds in the sequencer until rsp ready.

module frame_capability_table (
    input  logic      clk,
    input  logic      rst_n,
    fct_req_if.sink   req,
    fct_rsp_if.source rsp
);

    fct_pkg::dp_cmd_t cmd;
    fct_pkg::dp_sts_t sts;
    logic             ctrl_ready;

    // sequencer: decode, ram write, scan issue and result hand-off
    fct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (ctrl_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    assign req.ready = ctrl_ready;

    // datapath: entry ram, fill count, compare pipeline, result register
    fct_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req.req_type),
        .owner       (req.owner),
        .address     (req.address),
        .frames      (req.frames),
        .perm_bits   (req.perm_bits),
        .rsp_valid   (rsp.valid),
        .rsp_status  (rsp.status),
        .rsp_ready   (rsp.ready)
    );

    // a taken request closes the request channel until its result is queued
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while another is in flight");

    // never append into a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_entry |-> !sts.table_full)
        else $error("entry written into a full table");

    // a result is only loaded when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_rsp |-> sts.out_free)
        else $error("pending result overwritten");

    // full status is only reported for grants
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_rsp && (cmd.rsp_status == fct_pkg::STATUS_FULL)) |-> !sts.is_check)
        else $error("full status on a check");

endmodule
